[sv/bb3_pkg.sv]
// Shared types and constants for the 3x3 RGB box blur.
package bb3_pkg;

    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 4096;

    localparam int CH_W       = 8;
    localparam int WIDTH_W    = 10;
    localparam int HEIGHT_W   = 13;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int POS_W      = (COL_W + 1 > WIDTH_W) ? COL_W + 1 : WIDTH_W;
    localparam int SUM_W      = 12;
    localparam int CNT_W      = 4;
    localparam int CFG_ADDR_W = 3;
    localparam int REG_SEL_BIT = 2;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(MAX_WIDTH);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(MAX_HEIGHT);

    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_reg_sel;

    typedef struct packed {
        logic [CH_W-1:0] pixel_red;
        logic [CH_W-1:0] pixel_green;
        logic [CH_W-1:0] pixel_blue;
        logic            drain;
    } t_in_word;

    typedef struct packed {
        logic [CH_W-1:0] blurred_red;
        logic [CH_W-1:0] blurred_green;
        logic [CH_W-1:0] blurred_blue;
        logic            frame_last;
    } t_out_word;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_pixel;

    typedef struct packed {
        t_pixel older;
        t_pixel newer;
    } t_line_entry;

    typedef struct packed {
        logic       emit;
        logic       last;
        logic [2:0] row_ok;
        logic [2:0] col_ok;
    } t_pos_info;

    typedef struct packed {
        logic [SUM_W-1:0] sum_red;
        logic [SUM_W-1:0] sum_green;
        logic [SUM_W-1:0] sum_blue;
        logic [CNT_W-1:0] count;
        logic             last;
    } t_sum_word;

endpackage

[sv/bb3_scan.sv]
// Raster position tracking, frame-edge masks and result scheduling.
module bb3_scan (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_restart,
    input  logic [bb3_pkg::WIDTH_W-1:0]   i_width,
    input  logic [bb3_pkg::HEIGHT_W-1:0]  i_height,
    input  logic                          i_in_valid,
    input  bb3_pkg::t_in_word             i_in_word,
    output logic                          o_in_ready,
    input  logic                          i_next_ready,
    output logic                          o_pass_valid,
    output logic [bb3_pkg::COL_W-1:0]     o_addr,
    output bb3_pkg::t_pixel               o_cur,
    output bb3_pkg::t_pos_info            o_info
);
    import bb3_pkg::*;

    logic [COL_W-1:0]    r_col;
    logic [HEIGHT_W-1:0] r_row;

    logic                accept;
    logic                in_frame;
    logic                ignore_item;
    logic                col_first;
    logic                emit;
    logic                last;
    logic                wrap;
    logic [POS_W-1:0]    col_inc;
    logic [POS_W-1:0]    width_ext;
    logic [POS_W-1:0]    ocol;
    logic [POS_W:0]      ocol_ext;
    logic [POS_W:0]      w_cmp;
    logic [HEIGHT_W-1:0] orow;
    logic [HEIGHT_W:0]   orow_ext;
    logic [HEIGHT_W:0]   h_cmp;

    always_comb begin
        accept      = i_in_valid && i_next_ready;
        in_frame    = r_row < i_height;
        ignore_item = i_in_word.drain && in_frame;
        col_first   = (r_col == '0);
        emit        = (r_row >= HEIGHT_W'(2)) || ((r_row == HEIGHT_W'(1)) && !col_first);
        width_ext   = POS_W'(i_width);
        col_inc     = POS_W'(r_col) + POS_W'(1);
        wrap        = col_inc >= width_ext;
        orow        = col_first ? r_row - HEIGHT_W'(2) : r_row - HEIGHT_W'(1);
        ocol        = col_first ? width_ext - POS_W'(1) : POS_W'(r_col) - POS_W'(1);
        orow_ext    = {1'b0, orow};
        ocol_ext    = {1'b0, ocol};
        h_cmp       = {1'b0, i_height};
        w_cmp       = {1'b0, width_ext};
        last        = emit && (orow == i_height - HEIGHT_W'(1))
                      && (ocol == width_ext - POS_W'(1));

        o_info.emit      = emit;
        o_info.last      = last;
        o_info.row_ok[0] = (orow != '0) && ((orow_ext - (HEIGHT_W+1)'(1)) < h_cmp);
        o_info.row_ok[1] = orow_ext < h_cmp;
        o_info.row_ok[2] = (orow_ext + (HEIGHT_W+1)'(1)) < h_cmp;
        o_info.col_ok[0] = (ocol != '0) && ((ocol_ext - (POS_W+1)'(1)) < w_cmp);
        o_info.col_ok[1] = ocol_ext < w_cmp;
        o_info.col_ok[2] = (ocol_ext + (POS_W+1)'(1)) < w_cmp;

        o_in_ready   = i_next_ready;
        o_pass_valid = accept && !ignore_item;
        o_addr       = r_col;
        if (in_frame) begin
            o_cur.red   = i_in_word.pixel_red;
            o_cur.green = i_in_word.pixel_green;
            o_cur.blue  = i_in_word.pixel_blue;
        end else begin
            o_cur = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_restart) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept && !ignore_item) begin
            if (last) begin
                r_col <= '0;
                r_row <= '0;
            end else if (wrap) begin
                r_col <= '0;
                r_row <= r_row + HEIGHT_W'(1);
            end else begin
                r_col <= COL_W'(col_inc);
            end
        end
    end

endmodule

[sv/bb3_line_window.sv]
// Line store read-modify-write, 3x3 window and masked neighbourhood sums.
module bb3_line_window (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_pass_valid,
    input  logic [bb3_pkg::COL_W-1:0] i_addr,
    input  bb3_pkg::t_pixel           i_cur,
    input  bb3_pkg::t_pos_info        i_info,
    output logic                      o_ready,
    output logic                      o_avg_valid,
    input  logic                      i_avg_ready,
    output bb3_pkg::t_sum_word        o_avg_word
);
    import bb3_pkg::*;

    t_line_entry      mem [MAX_WIDTH];
    t_line_entry      r_mem_q;
    t_line_entry      r_fwd_data;
    logic             r_fwd;

    logic             r_s1_valid;
    logic [COL_W-1:0] r_s1_addr;
    t_pixel           r_s1_cur;
    t_pos_info        r_s1_info;

    t_pixel           r_win [3][3];
    logic             r_s2_valid;
    t_pos_info        r_s2_info;

    t_line_entry      line_rd;
    t_line_entry      line_wr;
    logic             s1_move;
    logic             s2_free;
    logic             s2_done;
    logic [SUM_W-1:0] row_red [3];
    logic [SUM_W-1:0] row_green [3];
    logic [SUM_W-1:0] row_blue [3];

    always_comb begin
        s2_done       = r_s2_valid && (!r_s2_info.emit || i_avg_ready);
        s2_free       = !r_s2_valid || s2_done;
        s1_move       = r_s1_valid && s2_free;
        o_ready       = !r_s1_valid || s2_free;
        line_rd       = r_fwd ? r_fwd_data : r_mem_q;
        line_wr.older = line_rd.newer;
        line_wr.newer = r_s1_cur;
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            mem[r_s1_addr] <= line_wr;
        end
        if (i_pass_valid) begin
            r_mem_q    <= mem[i_addr];
            r_fwd_data <= line_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd      <= 1'b0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (i_pass_valid) begin
                r_fwd <= s1_move && (r_s1_addr == i_addr);
            end
            if (i_pass_valid) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_s2_valid <= 1'b1;
            end else if (s2_done) begin
                r_s2_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pass_valid) begin
            r_s1_addr <= i_addr;
            r_s1_cur  <= i_cur;
            r_s1_info <= i_info;
        end
        if (s1_move) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= line_rd.older;
            r_win[1][2] <= line_rd.newer;
            r_win[2][2] <= r_s1_cur;
            r_s2_info   <= r_s1_info;
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            row_red[r]   = '0;
            row_green[r] = '0;
            row_blue[r]  = '0;
            for (int c = 0; c < 3; c++) begin
                if (r_s2_info.row_ok[r] && r_s2_info.col_ok[c]) begin
                    row_red[r]   = row_red[r] + SUM_W'(r_win[r][c].red);
                    row_green[r] = row_green[r] + SUM_W'(r_win[r][c].green);
                    row_blue[r]  = row_blue[r] + SUM_W'(r_win[r][c].blue);
                end
            end
        end
        o_avg_word.sum_red   = row_red[0] + row_red[1] + row_red[2];
        o_avg_word.sum_green = row_green[0] + row_green[1] + row_green[2];
        o_avg_word.sum_blue  = row_blue[0] + row_blue[1] + row_blue[2];
        o_avg_word.count     = CNT_W'($countones(r_s2_info.row_ok))
                               * CNT_W'($countones(r_s2_info.col_ok));
        o_avg_word.last      = r_s2_info.last;
        o_avg_valid          = r_s2_valid && r_s2_info.emit;
    end

endmodule

[sv/bb3_average.sv]
// Rounded division of the neighbourhood sums and the output register.
module bb3_average (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  bb3_pkg::t_sum_word i_sum_word,
    output logic               o_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output bb3_pkg::t_out_word o_out_word
);
    import bb3_pkg::*;

    localparam int NUM_W       = SUM_W + 1;
    localparam int RECIP_W     = 16;
    localparam int RECIP_SHIFT = 16;
    localparam logic [RECIP_W-1:0] RECIP_3 = 16'd21846;
    localparam logic [RECIP_W-1:0] RECIP_9 = 16'd7282;

    function automatic logic [CH_W-1:0] round_avg(input logic [SUM_W-1:0] sum,
                                                  input logic [CNT_W-1:0] count);
        logic [NUM_W-1:0]         num;
        logic [SUM_W-1:0]         x;
        logic [RECIP_W-1:0]       m;
        logic [SUM_W+RECIP_W-1:0] prod;
        logic [CH_W-1:0]          q;
        num = {sum, 1'b0} + NUM_W'(count);
        x   = '0;
        m   = '0;
        q   = '0;
        case (count)
            4'd1: q = CH_W'(num >> 1);
            4'd2: q = CH_W'(num >> 2);
            4'd4: q = CH_W'(num >> 3);
            4'd3: begin
                x = SUM_W'(num >> 1);
                m = RECIP_3;
            end
            4'd6: begin
                x = SUM_W'(num >> 2);
                m = RECIP_3;
            end
            4'd9: begin
                x = SUM_W'(num >> 1);
                m = RECIP_9;
            end
            default: q = '0;
        endcase
        prod = (SUM_W+RECIP_W)'(x) * (SUM_W+RECIP_W)'(m);
        if (m != '0) begin
            q = prod[RECIP_SHIFT +: CH_W];
        end
        return q;
    endfunction

    logic      r_s3_valid;
    t_sum_word r_s3;
    logic      r_out_valid;
    t_out_word r_out;
    logic      out_free;
    t_out_word n_out;

    always_comb begin
        out_free            = !r_out_valid || i_out_ready;
        o_ready             = !r_s3_valid || out_free;
        n_out.blurred_red   = round_avg(r_s3.sum_red, r_s3.count);
        n_out.blurred_green = round_avg(r_s3.sum_green, r_s3.count);
        n_out.blurred_blue  = round_avg(r_s3.sum_blue, r_s3.count);
        n_out.frame_last    = r_s3.last;
        o_out_valid         = r_out_valid;
        o_out_word          = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_s3_valid <= i_valid;
            end
            if (out_free) begin
                r_out_valid <= r_s3_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_s3 <= i_sum_word;
        end
        if (out_free && r_s3_valid) begin
            r_out <= n_out;
        end
    end

endmodule

[sv/box_blur_3x3_rgb_unit.sv]
// Top level of the streaming 3x3 RGB box blur with its APB register port.
//
//  Channel | Handshake                | Word / access
//  --------+--------------------------+---------------------------------------------
//  input   | i_in_valid / o_in_ready  | t_in_word: pixel colour, drain flag
//  output  | o_out_valid / i_out_ready| t_out_word: blurred colour, frame_last
//  config  | psel, penable, pwrite    | image_width at 0x0, image_height at 0x4
//
// One word is accepted per clock while o_in_ready is high; the word that completes
// a result's window passes the line-stage, window, sum and output registers before
// o_out_valid rises. The line store is read when a word is taken and written back
// as that word leaves the line stage, with the pending write forwarded when a
// one-pixel-wide row hits the same entry. Reset clears counters and stage valids;
// the line store is not cleared, as entries outside the frame are masked. A stalled
// output fills the stages one by one before o_in_ready falls.
module box_blur_3x3_rgb_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bb3_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  bb3_pkg::t_in_word              i_in_word,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output bb3_pkg::t_out_word             o_out_word
);
    import bb3_pkg::*;

    logic [WIDTH_W-1:0]  r_image_width;
    logic [HEIGHT_W-1:0] r_image_height;
    logic [WIDTH_W-1:0]  width_eff;
    logic [HEIGHT_W-1:0] height_eff;
    logic                cfg_write;
    t_reg_sel            reg_sel;

    logic                lw_ready;
    logic                pass_valid;
    logic [COL_W-1:0]    pass_addr;
    t_pixel              pass_cur;
    t_pos_info           pass_info;
    logic                avg_valid;
    logic                avg_ready;
    t_sum_word           avg_word;

    always_comb begin
        pready    = 1'b1;
        cfg_write = psel && penable && pwrite;
        reg_sel   = t_reg_sel'(paddr[REG_SEL_BIT]);
        case (reg_sel)
            REG_IMAGE_WIDTH:  prdata = 32'(r_image_width);
            REG_IMAGE_HEIGHT: prdata = 32'(r_image_height);
            default:          prdata = '0;
        endcase

        if (r_image_width == '0) begin
            width_eff = WIDTH_W'(1);
        end else if (r_image_width > WIDTH_RESET) begin
            width_eff = WIDTH_RESET;
        end else begin
            width_eff = r_image_width;
        end
        if (r_image_height == '0) begin
            height_eff = HEIGHT_W'(1);
        end else if (r_image_height > HEIGHT_RESET) begin
            height_eff = HEIGHT_RESET;
        end else begin
            height_eff = r_image_height;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= WIDTH_RESET;
            r_image_height <= HEIGHT_RESET;
        end else if (cfg_write) begin
            case (reg_sel)
                REG_IMAGE_WIDTH:  r_image_width  <= pwdata[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: r_image_height <= pwdata[HEIGHT_W-1:0];
                default:          r_image_width  <= r_image_width;
            endcase
        end
    end

    bb3_scan u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_restart    (cfg_write),
        .i_width      (width_eff),
        .i_height     (height_eff),
        .i_in_valid   (i_in_valid),
        .i_in_word    (i_in_word),
        .o_in_ready   (o_in_ready),
        .i_next_ready (lw_ready),
        .o_pass_valid (pass_valid),
        .o_addr       (pass_addr),
        .o_cur        (pass_cur),
        .o_info       (pass_info)
    );

    bb3_line_window u_line_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pass_valid (pass_valid),
        .i_addr       (pass_addr),
        .i_cur        (pass_cur),
        .i_info       (pass_info),
        .o_ready      (lw_ready),
        .o_avg_valid  (avg_valid),
        .i_avg_ready  (avg_ready),
        .o_avg_word   (avg_word)
    );

    bb3_average u_average (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (avg_valid),
        .i_sum_word   (avg_word),
        .o_ready      (avg_ready),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_word   (o_out_word)
    );

endmodule
